// ----- rtl/acfp_pkg.sv -----
`default_nettype none

package acfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned PHASE_W = 2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_READ      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MALFORMED = 2'd2;

    // register indexes
    localparam logic REG_START_BYTE = 1'b0;
    localparam logic REG_END_BYTE   = 1'b1;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd46;
    localparam logic [BYTE_W-1:0] END_BYTE_RESET   = 8'd10;

    // number parser phases
    localparam logic [PHASE_W-1:0] PH_BLANK  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SIGN   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DIGITS = 2'd2;
    localparam logic [PHASE_W-1:0] PH_STOP   = 2'd3;

    localparam logic [VALUE_W+3:0] POS_LIMIT = 36'h0_7FFF_FFFF;
    localparam logic [VALUE_W+3:0] NEG_LIMIT = 36'h0_8000_0000;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               negative;
        logic [VALUE_W-1:0] magnitude;
        logic               clamped;
    } t_num;

    function automatic logic is_blank(input logic [BYTE_W-1:0] b);
        return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
    endfunction

    // one byte of the decimal parser, with clamping at the signed limits
    function automatic t_num parse_byte(input t_num cur, input logic [BYTE_W-1:0] b);
        t_num             nxt;
        logic [VALUE_W+3:0] prod;
        logic [VALUE_W+3:0] limit;
        logic [BYTE_W-1:0]  digit;
        nxt   = cur;
        digit = b - 8'd48;
        prod  = ({4'd0, cur.magnitude} << 3) + ({4'd0, cur.magnitude} << 1)
              + {{(VALUE_W-4){1'b0}}, digit};
        limit = cur.negative ? NEG_LIMIT : POS_LIMIT;
        if (cur.phase != PH_STOP) begin
            if ((b >= 8'd48) && (b <= 8'd57)) begin
                if (prod > limit) begin
                    nxt.magnitude = limit[VALUE_W-1:0];
                    nxt.clamped   = 1'b1;
                end else begin
                    nxt.magnitude = prod[VALUE_W-1:0];
                end
                nxt.phase = PH_DIGITS;
            end else if ((cur.phase == PH_BLANK) && is_blank(b)) begin
                nxt.phase = PH_BLANK;
            end else if ((cur.phase == PH_BLANK) && ((b == 8'd43) || (b == 8'd45))) begin
                nxt.negative = (b == 8'd45);
                nxt.phase    = PH_SIGN;
            end else begin
                nxt.phase = PH_STOP;
            end
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ascii_command_frame_parser_top.sv -----
// ascii command frame parser
//
// input channel: one received serial byte per request on i_rx_byte, taken at a
// rising edge with i_in_valid high and o_in_stall low. output channel: one
// decoded command per request (kind, address, value, saturation flag), taken
// at a rising edge with o_out_valid high and i_out_stall low.
// the frame state and the result register are both updated at the edge that
// accepts a byte, so a closing byte shows its result on the outputs in the
// cycle after acceptance. throughput is one byte per cycle while the input is
// not stalled, set by the combinational multiply-by-ten accumulate.
// the input is stalled only while a result sits in the output register and
// the receiver stalls; every byte waits then, whether it closes a frame or
// not. the result and its fields hold until taken.
// reset (synchronous, active low) empties the output register, closes any
// open frame and restores the start byte to '.' and the end byte to newline.
// the two registers are written through i_cfg_we / i_cfg_index / i_cfg_data
// and should only change while no frame is in flight.
`default_nettype none

module ascii_command_frame_parser_top #(
    parameter int unsigned MAX_FRAME_BYTES = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // byte input
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [acfp_pkg::BYTE_W-1:0]   i_rx_byte,
    // command output
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [acfp_pkg::KIND_W-1:0]        o_kind,
    output logic [acfp_pkg::BYTE_W-1:0]        o_address,
    output logic signed [acfp_pkg::VALUE_W-1:0] o_value,
    output logic                               o_value_saturated,
    // register writes
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [acfp_pkg::BYTE_W-1:0]   i_cfg_data
);

    localparam logic [acfp_pkg::COUNT_W-1:0] MAX_COUNT =
        acfp_pkg::COUNT_W'(MAX_FRAME_BYTES);

    // configuration
    logic [acfp_pkg::BYTE_W-1:0]  r_start_byte;
    logic [acfp_pkg::BYTE_W-1:0]  r_end_byte;

    // frame state
    logic                         r_in_frame, n_in_frame;
    logic [acfp_pkg::COUNT_W-1:0] r_frame_count, n_frame_count;
    logic [acfp_pkg::BYTE_W-1:0]  r_letter, n_letter;
    acfp_pkg::t_num               r_num, n_num;

    // result register
    logic                         r_out_valid, n_out_valid;
    logic [acfp_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [acfp_pkg::BYTE_W-1:0]  r_address, n_address;
    logic [acfp_pkg::VALUE_W-1:0] r_value, n_value;
    logic                         r_sat, n_sat;

    logic                         in_accept;
    logic                         out_free;
    logic [acfp_pkg::COUNT_W-1:0] count_inc;
    acfp_pkg::t_num               num_step;
    acfp_pkg::t_num               num_clear;

    // the input only waits when a finished result cannot leave
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign count_inc  = r_frame_count + 1'b1;
    assign num_step   = acfp_pkg::parse_byte(r_num, i_rx_byte);
    assign num_clear  = '{phase: acfp_pkg::PH_BLANK, negative: 1'b0,
                          magnitude: '0, clamped: 1'b0};

    always_comb begin
        n_in_frame    = r_in_frame;
        n_frame_count = r_frame_count;
        n_letter      = r_letter;
        n_num         = r_num;
        n_out_valid   = out_free ? 1'b0 : r_out_valid;
        n_kind        = r_kind;
        n_address     = r_address;
        n_value       = r_value;
        n_sat         = r_sat;

        if (in_accept) begin
            if (!r_in_frame) begin
                // idle: only the start byte matters
                if (i_rx_byte == r_start_byte) begin
                    if (i_rx_byte == r_end_byte) begin
                        // start and end coincide: empty frame at once
                        n_out_valid = 1'b1;
                        n_kind      = acfp_pkg::KIND_MALFORMED;
                        n_address   = '0;
                        n_value     = '0;
                        n_sat       = 1'b0;
                    end else begin
                        n_in_frame    = 1'b1;
                        n_frame_count = acfp_pkg::COUNT_W'(1);
                    end
                end
            end else if (i_rx_byte == r_end_byte) begin
                // closing byte
                n_out_valid = 1'b1;
                if (count_inc <= acfp_pkg::COUNT_W'(2)) begin
                    n_kind    = acfp_pkg::KIND_MALFORMED;
                    n_address = '0;
                    n_value   = '0;
                    n_sat     = 1'b0;
                end else if (count_inc == acfp_pkg::COUNT_W'(3)) begin
                    n_kind    = acfp_pkg::KIND_READ;
                    n_address = r_letter;
                    n_value   = '0;
                    n_sat     = 1'b0;
                end else begin
                    // closing byte still runs through the parser
                    n_kind    = acfp_pkg::KIND_WRITE;
                    n_address = r_letter;
                    n_value   = num_step.negative ? (~num_step.magnitude + 1'b1)
                                                  : num_step.magnitude;
                    n_sat     = num_step.clamped;
                end
                n_in_frame    = 1'b0;
                n_frame_count = '0;
                n_letter      = '0;
                n_num         = num_clear;
            end else begin
                n_frame_count = count_inc;
                if (count_inc == acfp_pkg::COUNT_W'(2)) begin
                    n_letter = i_rx_byte;
                end else begin
                    n_num = num_step;
                end
                // overlong frame is dropped with no result
                if (count_inc > MAX_COUNT) begin
                    n_in_frame    = 1'b0;
                    n_frame_count = '0;
                    n_letter      = '0;
                    n_num         = num_clear;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= acfp_pkg::START_BYTE_RESET;
            r_end_byte    <= acfp_pkg::END_BYTE_RESET;
            r_in_frame    <= 1'b0;
            r_frame_count <= '0;
            r_letter      <= '0;
            r_num         <= num_clear;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    acfp_pkg::REG_START_BYTE: r_start_byte <= i_cfg_data;
                    acfp_pkg::REG_END_BYTE:   r_end_byte   <= i_cfg_data;
                    default:                  r_end_byte   <= r_end_byte;
                endcase
            end
            r_in_frame    <= n_in_frame;
            r_frame_count <= n_frame_count;
            r_letter      <= n_letter;
            r_num         <= n_num;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_address <= n_address;
        r_value   <= n_value;
        r_sat     <= n_sat;
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_kind;
    assign o_address         = r_address;
    assign o_value           = r_value;
    assign o_value_saturated = r_sat;

endmodule

`default_nettype wire

// ----- rtl/acfp_checker.sv -----
`default_nettype none

module acfp_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_stall,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [acfp_pkg::KIND_W-1:0]   i_kind,
    input wire logic [acfp_pkg::VALUE_W-1:0]  i_value,
    input wire logic                          i_value_saturated
);

    // input only stalls behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> (i_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    // a new result needs a byte accepted on the previous edge
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && !i_in_stall))
        else $error("result appeared without an accepted byte");

    // only writes carry a value or a saturation flag
    a_payload_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind != acfp_pkg::KIND_WRITE))
            |-> ((i_value == '0) && !i_value_saturated))
        else $error("read or malformed result with payload");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall)
            |=> (i_out_valid && $stable(i_kind) && $stable(i_value)))
        else $error("stalled result changed");

endmodule

bind ascii_command_frame_parser_top acfp_checker u_acfp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .i_in_stall       (o_in_stall),
    .i_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .i_kind           (o_kind),
    .i_value          (o_value),
    .i_value_saturated(o_value_saturated)
);

`default_nettype wire
